// ----- rtl/salsa_core_random_generator_macros.svh -----
// Assertion macros shared by the random generator core modules.
`ifndef SALSA_CORE_RANDOM_GENERATOR_MACROS_SVH
`define SALSA_CORE_RANDOM_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every clk edge outside reset.
`define SCRG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scrg: same-cycle check failed");
// Next-cycle implication, checked on every clk edge outside reset.
`define SCRG_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scrg: next-cycle check failed");
`else
`define SCRG_ASSERT_IMP(name, ante, cons)
`define SCRG_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ----- rtl/scrg_pkg.sv -----
// Shared constants, types and helper functions of the random generator core.
package scrg_pkg;

  localparam int ROUND_COUNT    = 10;
  localparam int MAX_READ_BYTES = 4096;
  localparam int BLOCK_BYTES    = 64;
  localparam int WORDS          = 16;

  // Rounds are run in column/row pairs, so an odd count is rounded up.
  localparam int NUM_ROUNDS = 2 * ((ROUND_COUNT + 1) / 2);
  localparam int ROUND_W    = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;

  localparam int CNT_W   = 17;
  localparam int BYTES_W = 13;
  localparam int VB_W    = 7;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTROPY   = 1'b1;

  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 17'd2048;

  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_KEY  = 2'd1;
  localparam logic [1:0] CMD_BUF  = 2'd2;

  localparam logic [1:0] STEP_LAST = 2'd3;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [BYTES_W-1:0] byte_count;
    logic [3:0]         word_index;
    logic [31:0]        word_value;
    logic [7:0][63:0]   entropy;
  } in_item_t;

  typedef struct packed {
    logic [7:0][63:0] block_words;
    logic [VB_W-1:0]  valid_bytes;
    logic             last_block;
  } out_item_t;

  typedef struct packed {
    logic       accept;
    logic       step_en;
    logic [1:0] step;
    logic       emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic read_req;
    logic last_block;
    logic out_free;
  } dp_status_t;

  // Rotation of one quarter-round step: 7, 9, 13, then 18.
  function automatic word_t rotl_step(input word_t v, input logic [1:0] step);
    word_t r;
    case (step)
      2'd0: r = {v[24:0], v[31:25]};
      2'd1: r = {v[22:0], v[31:23]};
      2'd2: r = {v[18:0], v[31:19]};
      default: r = {v[13:0], v[31:14]};
    endcase
    return r;
  endfunction

  // Word index of position pos (a, b, c, d) of column quarter q.
  function automatic logic [3:0] col_idx(input int q, input int pos);
    return 4'(5 * q + 4 * pos);
  endfunction

endpackage

// ----- rtl/scrg_if.sv -----
// Word channels of the random generator core: request input and block output.
interface scrg_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      command;
  logic [scrg_pkg::BYTES_W-1:0]    byte_count;
  logic [3:0]                      word_index;
  logic [31:0]                     word_value;
  logic [63:0]                     entropy_0;
  logic [63:0]                     entropy_1;
  logic [63:0]                     entropy_2;
  logic [63:0]                     entropy_3;
  logic [63:0]                     entropy_4;
  logic [63:0]                     entropy_5;
  logic [63:0]                     entropy_6;
  logic [63:0]                     entropy_7;

  modport source (
    output valid, command, byte_count, word_index, word_value,
    output entropy_0, entropy_1, entropy_2, entropy_3,
    output entropy_4, entropy_5, entropy_6, entropy_7,
    input  ready
  );
  modport sink (
    input  valid, command, byte_count, word_index, word_value,
    input  entropy_0, entropy_1, entropy_2, entropy_3,
    input  entropy_4, entropy_5, entropy_6, entropy_7,
    output ready
  );
endinterface

interface scrg_out_if;
  logic                         valid;
  logic                         ready;
  logic [63:0]                  block_words_0;
  logic [63:0]                  block_words_1;
  logic [63:0]                  block_words_2;
  logic [63:0]                  block_words_3;
  logic [63:0]                  block_words_4;
  logic [63:0]                  block_words_5;
  logic [63:0]                  block_words_6;
  logic [63:0]                  block_words_7;
  logic [scrg_pkg::VB_W-1:0]    valid_bytes;
  logic                         last_block;

  modport source (
    output valid, block_words_0, block_words_1, block_words_2, block_words_3,
    output block_words_4, block_words_5, block_words_6, block_words_7,
    output valid_bytes, last_block,
    input  ready
  );
  modport sink (
    input  valid, block_words_0, block_words_1, block_words_2, block_words_3,
    input  block_words_4, block_words_5, block_words_6, block_words_7,
    input  valid_bytes, last_block,
    output ready
  );
endinterface

// ----- rtl/salsa_core_random_generator.sv -----
// Top level of the Salsa-core random generator: sequencer plus datapath.
// A read of N bytes gives ceil(N/64) blocks, N capped at 4096; each block takes 40 round
// steps on the shared quarter-round unit, one step of all four quarters per cycle,
// then the key is added as the block is written into the free output register.
// Synchronous reset clears key, buffer and counter, sets threshold 2048, entropy on.
module salsa_core_random_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  scrg_in_if.sink                           in_ch,
  scrg_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [scrg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [scrg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import scrg_pkg::*;

  in_item_t   in_item;
  out_item_t  out_item;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  always_comb begin
    in_item.command    = in_ch.command;
    in_item.byte_count = in_ch.byte_count;
    in_item.word_index = in_ch.word_index;
    in_item.word_value = in_ch.word_value;
    in_item.entropy[0] = in_ch.entropy_0;
    in_item.entropy[1] = in_ch.entropy_1;
    in_item.entropy[2] = in_ch.entropy_2;
    in_item.entropy[3] = in_ch.entropy_3;
    in_item.entropy[4] = in_ch.entropy_4;
    in_item.entropy[5] = in_ch.entropy_5;
    in_item.entropy[6] = in_ch.entropy_6;
    in_item.entropy[7] = in_ch.entropy_7;
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.block_words_0 = out_item.block_words[0];
  assign out_ch.block_words_1 = out_item.block_words[1];
  assign out_ch.block_words_2 = out_item.block_words[2];
  assign out_ch.block_words_3 = out_item.block_words[3];
  assign out_ch.block_words_4 = out_item.block_words[4];
  assign out_ch.block_words_5 = out_item.block_words[5];
  assign out_ch.block_words_6 = out_item.block_words[6];
  assign out_ch.block_words_7 = out_item.block_words[7];
  assign out_ch.valid_bytes   = out_item.valid_bytes;
  assign out_ch.last_block    = out_item.last_block;

  scrg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  scrg_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/scrg_ctrl.sv -----
// Sequencer of the random generator core: request intake, round counting, block hand-off.
`include "salsa_core_random_generator_macros.svh"

module scrg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scrg_pkg::dp_status_t status,
  output scrg_pkg::ctrl_cmd_t  cmd
);
  import scrg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [1:0]         step_r, step_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic               accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    round_nxt = round_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && status.read_req) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
          round_nxt = '0;
        end
      end
      ST_RUN: begin
        step_nxt = 2'(step_r + 2'd1);
        if (step_r == STEP_LAST) begin
          if (round_r == ROUND_W'(NUM_ROUNDS - 1)) begin
            state_nxt = ST_DONE;
            round_nxt = '0;
          end else begin
            round_nxt = ROUND_W'(round_r + 1'b1);
          end
        end
      end
      ST_DONE: begin
        // The state already holds the next block's start, so the next block can
        // run while this result waits in the output register.
        if (status.out_free) begin
          state_nxt = status.last_block ? ST_IDLE : ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
        round_nxt = '0;
      end
    endcase
  end

  always_comb begin
    cmd.accept  = accept;
    cmd.step_en = (state_r == ST_RUN);
    cmd.step    = step_r;
    cmd.emit    = (state_r == ST_DONE) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      round_r <= round_nxt;
    end
  end

  `SCRG_ASSERT_NXT(a_read_starts, accept && status.read_req, (state_r == ST_RUN) && (step_r == 2'd0) && (round_r == '0))
  `SCRG_ASSERT_NXT(a_step_advances, state_r == ST_RUN, step_r == 2'($past(step_r) + 2'd1))
  `SCRG_ASSERT_IMP(a_counters_parked, state_r != ST_RUN, (step_r == 2'd0) && (round_r == '0))

endmodule

// ----- rtl/scrg_datapath.sv -----
// Datapath of the random generator core: key, buffer, round state, counter, output block.
`include "salsa_core_random_generator_macros.svh"

module scrg_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  scrg_pkg::in_item_t                in_item,
  input  logic                              cfg_we,
  input  logic [scrg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [scrg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  scrg_pkg::ctrl_cmd_t               cmd,
  output scrg_pkg::dp_status_t              status,
  input  logic                              out_ready,
  output logic                              out_valid,
  output scrg_pkg::out_item_t               out_item
);
  import scrg_pkg::*;

  word_t              key_r [WORDS];
  word_t              buf_r [WORDS];
  word_t              x_r   [WORDS];
  word_t              x_step  [WORDS];
  word_t              x_round [WORDS];
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   thr_r;
  logic               ent_en_r;
  logic [BYTES_W-1:0] rem_r;
  out_item_t          out_r;
  logic               out_valid_r;

  logic               read_req;
  logic [BYTES_W-1:0] count_sat;
  logic [CNT_W:0]     sum;
  logic [CNT_W-1:0]   sum_sat;
  logic               reseed;
  logic               last;

  assign read_req  = (in_item.command == CMD_READ) && (in_item.byte_count != '0);
  assign count_sat = (in_item.byte_count > BYTES_W'(MAX_READ_BYTES)) ?
                     BYTES_W'(MAX_READ_BYTES) : in_item.byte_count;
  assign sum       = (CNT_W + 1)'(cnt_r) + (CNT_W + 1)'(count_sat);
  assign sum_sat   = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  assign reseed    = (sum_sat >= thr_r);
  assign last      = (rem_r <= BYTES_W'(BLOCK_BYTES));

  // One quarter-round step for all four quarters. The state is transposed at
  // the end of every round, so a row round runs as a column round.
  always_comb begin
    for (int w = 0; w < WORDS; w++) begin
      x_step[w] = x_r[w];
    end
    for (int q = 0; q < 4; q++) begin
      case (cmd.step)
        2'd0: x_step[col_idx(q, 1)] = x_r[col_idx(q, 1)] ^
              rotl_step(x_r[col_idx(q, 0)] + x_r[col_idx(q, 3)], cmd.step);
        2'd1: x_step[col_idx(q, 2)] = x_r[col_idx(q, 2)] ^
              rotl_step(x_r[col_idx(q, 1)] + x_r[col_idx(q, 0)], cmd.step);
        2'd2: x_step[col_idx(q, 3)] = x_r[col_idx(q, 3)] ^
              rotl_step(x_r[col_idx(q, 2)] + x_r[col_idx(q, 1)], cmd.step);
        default: x_step[col_idx(q, 0)] = x_r[col_idx(q, 0)] ^
              rotl_step(x_r[col_idx(q, 3)] + x_r[col_idx(q, 2)], cmd.step);
      endcase
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        x_round[4 * c + r] = (cmd.step == STEP_LAST) ? x_step[4 * r + c] : x_step[4 * c + r];
      end
    end
  end

  always_comb begin
    status.read_req   = read_req;
    status.last_block = last;
    status.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < WORDS; w++) begin
        key_r[w] <= '0;
        buf_r[w] <= '0;
      end
      cnt_r       <= '0;
      thr_r       <= THRESHOLD_RESET;
      ent_en_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_r    <= cfg_wdata[CNT_W-1:0];
          CFG_ENTROPY:   ent_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        case (in_item.command)
          CMD_KEY: key_r[in_item.word_index] <= in_item.word_value;
          CMD_BUF: buf_r[in_item.word_index] <= in_item.word_value;
          CMD_READ: begin
            if (read_req) begin
              cnt_r <= reseed ? '0 : sum_sat;
              if (reseed && ent_en_r) begin
                for (int k = 0; k < 8; k++) begin
                  key_r[2 * k]     <= key_r[2 * k]     ^ in_item.entropy[k][31:0];
                  key_r[2 * k + 1] <= key_r[2 * k + 1] ^ in_item.entropy[k][63:32];
                end
              end
            end
          end
          default: ;
        endcase
      end
      // The chaining buffer takes the state before the key is added.
      if (cmd.emit) begin
        for (int w = 0; w < WORDS; w++) begin
          buf_r[w] <= x_r[w];
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && read_req) begin
      for (int w = 0; w < WORDS; w++) begin
        x_r[w] <= buf_r[w];
      end
    end else if (cmd.step_en) begin
      for (int w = 0; w < WORDS; w++) begin
        x_r[w] <= x_round[w];
      end
    end
    if (cmd.accept && read_req) begin
      rem_r <= count_sat;
    end else if (cmd.emit) begin
      rem_r <= BYTES_W'(rem_r - BYTES_W'(BLOCK_BYTES));
    end
    if (cmd.emit) begin
      for (int k = 0; k < 8; k++) begin
        out_r.block_words[k] <= {x_r[2 * k + 1] + key_r[2 * k + 1], x_r[2 * k] + key_r[2 * k]};
      end
      out_r.valid_bytes <= last ? VB_W'(rem_r) : VB_W'(BLOCK_BYTES);
      out_r.last_block  <= last;
    end
  end

  `SCRG_ASSERT_NXT(a_valid_bytes_range, cmd.emit, (out_r.valid_bytes != '0) && (out_r.valid_bytes <= VB_W'(BLOCK_BYTES)))
  `SCRG_ASSERT_NXT(a_reseed_clears, cmd.accept && read_req && reseed, cnt_r == '0)
  `SCRG_ASSERT_NXT(a_more_blocks_left, cmd.emit && !last, rem_r != '0)

endmodule

// ----- tb/salsa_core_random_generator_tb.sv -----
// Self-checking testbench of the Salsa-core random generator, with its own block predictor.
module salsa_core_random_generator_tb;
  import scrg_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE_CYCLES = 60;
  localparam int TALLY_MAX = (1 << CNT_W) - 1;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [BYTES_W-1:0] byte_count;
    logic [3:0]         word_index;
    logic [31:0]        word_value;
    logic [63:0]        entropy;
    logic               typed;
    logic [63:0]        low_words;
    logic [63:0]        high_words;
    logic [VB_W-1:0]    tail_bytes;
  } probe_row_t;

  // Typed rows read from an all-zero buffer, so each block is simply the key.
  localparam int NUM_PROBES = 21;
  localparam probe_row_t PROBES [NUM_PROBES] = '{
    '{CMD_READ,  13'd1,    4'd0,  32'h0,        64'h0, 1'b1, 64'h0, 64'h0, 7'd1},
    '{CMD_READ,  13'd64,   4'd0,  32'h0,        64'h0, 1'b1, 64'h0, 64'h0, 7'd64},
    '{CMD_READ,  13'd0,    4'd0,  32'h0,        64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_SPARE, 13'd100,  4'd9,  32'hDEADBEEF, 64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_KEY,   13'd0,    4'd0,  32'hFFFFFFFF, 64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_KEY,   13'd0,    4'd15, 32'h80000001, 64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_READ,  13'd64,   4'd0,  32'h0,        64'h0, 1'b1,
      64'h0000_0000_FFFF_FFFF, 64'h8000_0001_0000_0000, 7'd64},
    '{CMD_READ,  13'd65,   4'd0,  32'h0,        64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_BUF,   13'd0,    4'd0,  32'h1,        64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_BUF,   13'd0,    4'd15, 32'hFFFFFFFF, 64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_BUF,   13'd0,    4'd7,  32'h5A5A5A5A, 64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_READ,  13'd128,  4'd0,  32'h0,        64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_READ,  13'd4096, 4'd0,  32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_READ,  13'd8191, 4'd3,  32'h0, 64'h0123_4567_89AB_CDEF, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_READ,  13'd4097, 4'd0,  32'h0,        64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_READ,  13'd63,   4'd0,  32'h0,        64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_KEY,   13'd0,    4'd5,  32'h0,        64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_READ,  13'd2047, 4'd0,  32'h0, 64'hA5A5_5A5A_C3C3_3C3C, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_READ,  13'd1,    4'd0,  32'h0,        64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_SPARE, 13'd0,    4'd0,  32'h0,        64'h0, 1'b0, 64'h0, 64'h0, 7'd0},
    '{CMD_READ,  13'd127,  4'd0,  32'h0,        64'h0, 1'b0, 64'h0, 64'h0, 7'd0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  scrg_in_if in_ch ();
  scrg_out_if out_ch ();

  salsa_core_random_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  word_t key_words [16];
  word_t chain_words [16];
  word_t mix_state [16];
  logic [CNT_W-1:0] byte_tally;
  logic [CNT_W-1:0] reseed_level;
  logic entropy_on;

  out_item_t pending_blocks [$];
  int mismatches = 0;
  int blocks_seen = 0;
  int cycle_count = 0;
  bit quiet_run = 1'b0;

  function automatic word_t rol32(input word_t v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void quarter_mix(input int a, input int b, input int c, input int d);
    mix_state[b] ^= rol32(mix_state[a] + mix_state[d], 7);
    mix_state[c] ^= rol32(mix_state[b] + mix_state[a], 9);
    mix_state[d] ^= rol32(mix_state[c] + mix_state[b], 13);
    mix_state[a] ^= rol32(mix_state[d] + mix_state[c], 18);
  endfunction

  // One output block: double rounds on the buffer, then the key on top.
  // The buffer keeps the state from before the key was added.
  function automatic out_item_t salsa_mix_block();
    out_item_t blk;
    int r;
    int i;
    blk = '0;
    mix_state = chain_words;
    for (r = 0; r < ROUND_COUNT; r += 2) begin
      quarter_mix(0, 4, 8, 12);
      quarter_mix(5, 9, 13, 1);
      quarter_mix(10, 14, 2, 6);
      quarter_mix(15, 3, 7, 11);
      quarter_mix(0, 1, 2, 3);
      quarter_mix(5, 6, 7, 4);
      quarter_mix(10, 11, 8, 9);
      quarter_mix(15, 12, 13, 14);
    end
    for (i = 0; i < 16; i++) begin
      blk.block_words[i / 2][32 * (i % 2) +: 32] = mix_state[i] + key_words[i];
    end
    chain_words = mix_state;
    return blk;
  endfunction

  function automatic void predict_request(input in_item_t w, input bit record);
    int n;
    int sum;
    int blocks;
    int i;
    int b;
    out_item_t blk;
    case (w.command)
      CMD_KEY: key_words[w.word_index] = w.word_value;
      CMD_BUF: chain_words[w.word_index] = w.word_value;
      CMD_READ: begin
        if (w.byte_count != 0) begin
          n = (w.byte_count > MAX_READ_BYTES) ? MAX_READ_BYTES : int'(w.byte_count);
          sum = int'(byte_tally) + n;
          if (sum > TALLY_MAX) sum = TALLY_MAX;
          byte_tally = CNT_W'(sum);
          if (byte_tally >= reseed_level) begin
            byte_tally = '0;
            if (entropy_on) begin
              for (i = 0; i < 16; i++) begin
                key_words[i] ^= w.entropy[i / 2][32 * (i % 2) +: 32];
              end
            end
          end
          blocks = (n + BLOCK_BYTES - 1) / BLOCK_BYTES;
          for (b = 0; b < blocks; b++) begin
            blk = salsa_mix_block();
            blk.last_block = (b == blocks - 1);
            blk.valid_bytes = blk.last_block ? VB_W'(n - b * BLOCK_BYTES) : VB_W'(BLOCK_BYTES);
            if (record) pending_blocks.push_back(blk);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly small reads, a few large and oversized ones; heavy gives only reads of 4096
  // to 8191 bytes. The flag tells whether the word does anything at all.
  function automatic in_item_t random_request(input bit heavy, output bit counts);
    in_item_t w;
    int roll;
    int sub;
    int k;
    w = '0;
    for (k = 0; k < 8; k++) w.entropy[k] = {$urandom, $urandom};
    w.word_index = 4'($urandom_range(0, 15));
    w.word_value = $urandom;
    w.byte_count = BYTES_W'($urandom_range(0, 8191));
    counts = 1'b1;
    roll = heavy ? 0 : $urandom_range(0, 99);
    if (roll < 62) begin
      w.command = CMD_READ;
      sub = $urandom_range(0, 99);
      if (heavy) w.byte_count = BYTES_W'($urandom_range(4096, 8191));
      else if (sub < 3) w.byte_count = '0;
      else if (sub < 90) w.byte_count = BYTES_W'($urandom_range(1, 256));
      else if (sub < 96) w.byte_count = BYTES_W'($urandom_range(257, 4096));
      else w.byte_count = BYTES_W'($urandom_range(4097, 8191));
      counts = (w.byte_count != 0);
    end else if (roll < 80) begin
      w.command = CMD_KEY;
    end else if (roll < 96) begin
      w.command = CMD_BUF;
    end else begin
      w.command = CMD_SPARE;
      counts = 1'b0;
    end
    return w;
  endfunction

  task automatic send_word(input in_item_t w);
    int gap;
    @(negedge clk);
    if (!quiet_run && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.command = w.command;
    in_ch.byte_count = w.byte_count;
    in_ch.word_index = w.word_index;
    in_ch.word_value = w.word_value;
    in_ch.entropy_0 = w.entropy[0];
    in_ch.entropy_1 = w.entropy[1];
    in_ch.entropy_2 = w.entropy[2];
    in_ch.entropy_3 = w.entropy[3];
    in_ch.entropy_4 = w.entropy[4];
    in_ch.entropy_5 = w.entropy[5];
    in_ch.entropy_6 = w.entropy[6];
    in_ch.entropy_7 = w.entropy[7];
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_THRESHOLD) reseed_level = data;
    else entropy_on = data[0];
  endtask

  // A write or an empty read may still be in flight when the last block has come.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] level, input logic present,
                           input int items, input bit heavy, input bit calm);
    int sent;
    bit counts;
    in_item_t w;
    settle();
    write_cfg(CFG_THRESHOLD, level);
    write_cfg(CFG_ENTROPY, CFG_DATA_W'(present));
    quiet_run = calm;
    sent = 0;
    while (sent < items) begin
      w = random_request(heavy, counts);
      send_word(w);
      predict_request(w, 1'b1);
      if (counts) sent++;
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_level();
    return ($urandom_range(0, 3) == 0) ? CFG_DATA_W'(65536) : CFG_DATA_W'($urandom_range(1, 600));
  endfunction

  function automatic void note_mismatch(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s of block %0d: expected %h, got %h", field, blocks_seen, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_blocks
    out_item_t got;
    out_item_t want;
    int k;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.block_words[0] = out_ch.block_words_0;
      got.block_words[1] = out_ch.block_words_1;
      got.block_words[2] = out_ch.block_words_2;
      got.block_words[3] = out_ch.block_words_3;
      got.block_words[4] = out_ch.block_words_4;
      got.block_words[5] = out_ch.block_words_5;
      got.block_words[6] = out_ch.block_words_6;
      got.block_words[7] = out_ch.block_words_7;
      got.valid_bytes = out_ch.valid_bytes;
      got.last_block = out_ch.last_block;
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected block %0d: nothing was requested", blocks_seen);
      end else begin
        want = pending_blocks.pop_front();
        for (k = 0; k < 8; k++) begin
          if (got.block_words[k] !== want.block_words[k]) begin
            note_mismatch($sformatf("block_words_%0d", k), want.block_words[k], got.block_words[k]);
          end
        end
        if (got.valid_bytes !== want.valid_bytes) begin
          note_mismatch("valid_bytes", 64'(want.valid_bytes), 64'(got.valid_bytes));
        end
        if (got.last_block !== want.last_block) begin
          note_mismatch("last_block", 64'(want.last_block), 64'(got.last_block));
        end
      end
      blocks_seen++;
    end
  end

  // Output stalls in bursts, with longer stretches of steady ready now and then.
  initial begin : drain_stalls
    int hold;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet_run && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 13);
        out_ch.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end else if (!quiet_run && $urandom_range(0, 40) == 0) begin
        hold = $urandom_range(50, 150);
        out_ch.ready = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  // At worst about 180 words each ask for 64 blocks, and every block may meet an output
  // stall; the limit leaves ample room.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int row;
    int k;
    in_item_t w;
    out_item_t typed_blk;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_READ;
    in_ch.byte_count = '0;
    in_ch.word_index = '0;
    in_ch.word_value = '0;
    in_ch.entropy_0 = '0;
    in_ch.entropy_1 = '0;
    in_ch.entropy_2 = '0;
    in_ch.entropy_3 = '0;
    in_ch.entropy_4 = '0;
    in_ch.entropy_5 = '0;
    in_ch.entropy_6 = '0;
    in_ch.entropy_7 = '0;
    for (k = 0; k < 16; k++) begin
      key_words[k] = '0;
      chain_words[k] = '0;
    end
    byte_tally = '0;
    reseed_level = THRESHOLD_RESET;
    entropy_on = 1'b1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    for (row = 0; row < NUM_PROBES; row++) begin
      w = '0;
      w.command = PROBES[row].command;
      w.byte_count = PROBES[row].byte_count;
      w.word_index = PROBES[row].word_index;
      w.word_value = PROBES[row].word_value;
      for (k = 0; k < 8; k++) w.entropy[k] = PROBES[row].entropy;
      send_word(w);
      predict_request(w, !PROBES[row].typed);
      if (PROBES[row].typed) begin
        typed_blk = '0;
        typed_blk.block_words[0] = PROBES[row].low_words;
        typed_blk.block_words[7] = PROBES[row].high_words;
        typed_blk.valid_bytes = PROBES[row].tail_bytes;
        typed_blk.last_block = 1'b1;
        pending_blocks.push_back(typed_blk);
      end
    end

    run_phase('0, 1'b1, 22, 1'b0, 1'b0);
    run_phase(CFG_DATA_W'(1), 1'b0, 22, 1'b0, 1'b0);
    // Thirty-two full reads drive the tally into saturation at the top threshold.
    run_phase(CFG_DATA_W'(TALLY_MAX), 1'b1, 32, 1'b1, 1'b0);
    repeat (3) run_phase(pick_level(), 1'($urandom_range(0, 1)), 20, 1'b0, 1'b0);
    run_phase(pick_level(), 1'b1, 20, 1'b0, 1'b1);
    settle();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
